// ----- rtl/core/dirv_pkg.sv -----
// Shared types and constants for the decimal integer range validator.
package dirv_pkg;

   localparam int CHAR_W    = 8;
   localparam int COUNT_W   = 5;
   localparam int MAG_W     = 64;
   localparam int BOUND_W   = 64;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 5'd20;
   localparam logic [MAG_W-1:0]   SIGN_BIT   = {1'b1, {(MAG_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] REG_LOW_BOUND  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_BOUND = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_VALID  = 2'd0,
      STATUS_FORMAT = 2'd1,
      STATUS_RANGE  = 2'd2
   } status_type;

   // Per-text summary handed from the accumulator to the classifier.
   typedef struct packed {
      logic               neg_sign;
      logic [COUNT_W-1:0] digit_count;
      logic [MAG_W-1:0]   magnitude;
      logic               too_large;
      logic               lead_zero;
      logic               format_bad;
   } text_sum_type;

endpackage

// ----- rtl/core/dirv_accum.sv -----
// Input register and per-text character accumulator.
module dirv_accum
   import dirv_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               req_valid,
   input  logic [CHAR_W-1:0]  req_char,
   input  logic               req_last,
   output logic               sum_valid,
   output text_sum_type       sum
);

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] char_ff;
   logic              last_ff;

   text_sum_type      state_ff, state_in;
   logic              seen_ff, seen_in;
   text_sum_type      next_state;
   text_sum_type      sum_ff, sum_in;
   logic              sum_valid_ff, sum_valid_in;

   logic              is_minus;
   logic              is_digit;
   logic [MAG_W-1:0]  digit;
   logic [MAG_W+3:0]  mag_x10;

   always_comb begin
      is_minus = (char_ff == CHAR_MINUS);
      is_digit = (char_ff inside {[CHAR_ZERO:CHAR_NINE]});
      digit    = MAG_W'(char_ff - CHAR_ZERO);
      mag_x10  = {1'b0, state_ff.magnitude, 3'b000} + {3'b000, state_ff.magnitude, 1'b0}
                 + {4'b0000, digit};

      next_state = state_ff;
      if (is_minus) begin
         if (seen_ff) begin
            next_state.format_bad = 1'b1;
         end else begin
            next_state.neg_sign = 1'b1;
         end
      end else if (is_digit) begin
         if (state_ff.digit_count == '0 && digit == '0) begin
            next_state.lead_zero = 1'b1;
         end
         if (state_ff.digit_count < COUNT_MAX) begin
            next_state.digit_count = state_ff.digit_count + COUNT_W'(1);
         end
         if (!state_ff.too_large) begin
            if (mag_x10[MAG_W+3:MAG_W] != 4'b0000) begin
               next_state.too_large = 1'b1;
               next_state.magnitude = '1;
            end else begin
               next_state.magnitude = mag_x10[MAG_W-1:0];
            end
         end
      end else begin
         next_state.format_bad = 1'b1;
      end
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      state_in     = state_ff;
      seen_in      = seen_ff;
      sum_in       = sum_ff;
      sum_valid_in = sum_valid_ff;
      if (advance) begin
         in_valid_in  = req_valid;
         sum_valid_in = 1'b0;
         if (in_valid_ff) begin
            if (last_ff) begin
               sum_in       = next_state;
               sum_valid_in = 1'b1;
               state_in     = '0;
               seen_in      = 1'b0;
            end else begin
               state_in = next_state;
               seen_in  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= '0;
         seen_ff      <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         sum_valid_ff <= sum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         char_ff <= req_char;
         last_ff <= req_last;
      end
      sum_ff <= sum_in;
   end

   assign sum_valid = sum_valid_ff;
   assign sum       = sum_ff;

   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      state_ff.digit_count <= COUNT_MAX)
      else $error("digit count above saturation limit");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid_ff && last_ff) |=> (state_ff == '0 && !seen_ff && sum_valid_ff))
      else $error("text state not cleared after last character");

   a_overflow_sat: assert property (@(posedge clock) disable iff (reset)
      state_ff.too_large |-> (state_ff.magnitude == '1))
      else $error("overflowed magnitude not saturated");

endmodule

// ----- rtl/core/dirv_classify.sv -----
// Two-stage classifier: format/overflow check and signed range compare.
module dirv_classify
   import dirv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                sum_valid,
   input  text_sum_type        sum,
   input  logic [BOUND_W-1:0]  low_bound,
   input  logic [BOUND_W-1:0]  high_bound,
   output logic                out_valid,
   output status_type          out_status
);

   logic               p_valid_ff, p_valid_in;
   logic               p_format_ff, p_format_in;
   logic               p_range_ff, p_range_in;
   logic [MAG_W-1:0]   p_bits_ff, p_bits_in;

   logic               o_valid_ff, o_valid_in;
   status_type         o_status_ff, o_status_in;

   logic               below_low;
   logic               above_high;

   always_comb begin
      p_format_in = sum.format_bad || sum.digit_count == '0
                    || (sum.lead_zero && (sum.neg_sign || sum.digit_count > 5'd1));
      if (sum.neg_sign) begin
         p_range_in = sum.too_large || sum.magnitude > SIGN_BIT;
         p_bits_in  = ~sum.magnitude + MAG_W'(1);
      end else begin
         p_range_in = sum.too_large || sum.magnitude >= SIGN_BIT;
         p_bits_in  = sum.magnitude;
      end
      p_valid_in = advance ? sum_valid : p_valid_ff;
   end

   always_comb begin
      below_low  = $signed(p_bits_ff) < $signed(low_bound);
      above_high = $signed(p_bits_ff) > $signed(high_bound);
      if (p_format_ff) begin
         o_status_in = STATUS_FORMAT;
      end else if (p_range_ff || below_low || above_high) begin
         o_status_in = STATUS_RANGE;
      end else begin
         o_status_in = STATUS_VALID;
      end
      o_valid_in = advance ? p_valid_ff : o_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_format_ff <= p_format_in;
         p_range_ff  <= p_range_in;
         p_bits_ff   <= p_bits_in;
         o_status_ff <= o_status_in;
      end
   end

   assign out_valid  = o_valid_ff;
   assign out_status = o_status_ff;

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && !advance) |=> (o_valid_ff && $stable(o_status_ff)))
      else $error("result changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      o_valid_ff |-> (o_status_ff == STATUS_VALID || o_status_ff == STATUS_FORMAT
                      || o_status_ff == STATUS_RANGE))
      else $error("undefined status code");

endmodule

// ----- rtl/core/decimal_integer_range_validator_core.sv -----
// Top level of the decimal integer range validator.
//
// Streams the characters of decimal integer texts, one transaction per
// character, with tlast on the final character. Each text yields exactly one
// result transaction carrying a status: 0 valid, 1 bad format (non-digit,
// misplaced minus, no digits, leading zero, "-0"), 2 outside the inclusive
// signed range [low_bound, high_bound] (including values that do not fit a
// signed 64-bit integer). A new character is accepted every cycle unless the
// pipeline stalls; after the last character is accepted, the result passes
// from the input register through the multiply-by-ten accumulator, the
// sign/overflow stage and the range compare stage. The pipeline stalls only
// while a result waits in the output register. Bounds reset to zero and
// should be written while no text is in flight.
module decimal_integer_range_validator_core
   import dirv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] char_code
   input  logic                 req_tlast,   // last_char
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [1:0] status, [7:2] zero
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BOUND_W-1:0]   csr_wdata
);

   logic               advance;
   logic               sum_valid;
   text_sum_type       sum;
   status_type         status;
   logic [BOUND_W-1:0] low_bound_ff, low_bound_in;
   logic [BOUND_W-1:0] high_bound_ff, high_bound_in;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      low_bound_in  = low_bound_ff;
      high_bound_in = high_bound_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_LOW_BOUND:  low_bound_in  = csr_wdata;
            REG_HIGH_BOUND: high_bound_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_bound_ff  <= '0;
         high_bound_ff <= '0;
      end else begin
         low_bound_ff  <= low_bound_in;
         high_bound_ff <= high_bound_in;
      end
   end

   dirv_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_tvalid),
      .req_char  (req_tdata[CHAR_W-1:0]),
      .req_last  (req_tlast),
      .sum_valid (sum_valid),
      .sum       (sum)
   );

   dirv_classify u_classify (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .sum_valid  (sum_valid),
      .sum        (sum),
      .low_bound  (low_bound_ff),
      .high_bound (high_bound_ff),
      .out_valid  (rsp_tvalid),
      .out_status (status)
   );

   assign rsp_tdata = {6'b000000, status};

endmodule

// ----- bench/decimal_integer_range_validator_core_tb.sv -----
// Self-checking regression bench for the decimal integer range validator core.
`timescale 1ns / 1ps

module decimal_integer_range_validator_core_tb;
   import dirv_pkg::*;

   localparam int NO_TYPED      = -1;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 4000;
   localparam int PHASE_CHARS   = 75;
   localparam int NUM_PHASES    = 6;
   localparam int DIR_ROWS      = 24;
   localparam logic [MAG_W-1:0]          MAG_ALL_ONES = {MAG_W{1'b1}};
   localparam logic signed [BOUND_W-1:0] BOUND_MIN    = {1'b1, {(BOUND_W-1){1'b0}}};
   localparam logic signed [BOUND_W-1:0] BOUND_MAX    = {1'b0, {(BOUND_W-1){1'b1}}};

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = 8'd0;   // [7:0] char_code
   logic                 req_tlast  = 1'b0;   // last_char
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;           // [1:0] status, [7:2] zero
   logic                 csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [BOUND_W-1:0]   csr_wdata  = '0;

   decimal_integer_range_validator_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow of the per-text state and the bounds
   logic                      txt_neg;
   logic [COUNT_W-1:0]        txt_count;
   logic [MAG_W-1:0]          txt_mag;
   logic                      txt_big;
   logic                      txt_lead;
   logic                      txt_bad;
   logic                      txt_begun;
   logic signed [BOUND_W-1:0] bound_lo;
   logic signed [BOUND_W-1:0] bound_hi;

   status_type status_due[$];
   logic [7:0] text_buf[$];
   int         fail_count    = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         stall_cycles  = 0;

   string dir_text [DIR_ROWS] = '{
      "0", "7", "-3", "-", "-0", "00", "0123", "12-3", "4a", "--1",
      "9223372036854775807", "-9223372036854775808", "9223372036854775808",
      "-9223372036854775809", "18446744073709551615", "99999999999999999999999",
      "-120", "5/", ":",
      "-50", "50", "-51", "51",
      "0"
   };
   int dir_want [DIR_ROWS] = '{
      STATUS_VALID, STATUS_RANGE, STATUS_RANGE, STATUS_FORMAT, STATUS_FORMAT,
      STATUS_FORMAT, STATUS_FORMAT, STATUS_FORMAT, STATUS_FORMAT, STATUS_FORMAT,
      STATUS_VALID, STATUS_VALID, STATUS_RANGE, STATUS_RANGE, STATUS_RANGE,
      STATUS_RANGE, STATUS_VALID, STATUS_FORMAT, STATUS_FORMAT,
      NO_TYPED, NO_TYPED, NO_TYPED, NO_TYPED,
      STATUS_RANGE
   };
   int dir_group [DIR_ROWS] = '{
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
      1, 1, 1, 1, 1, 1, 1, 1, 1,
      2, 2, 2, 2,
      3
   };
   // group 0 runs on the reset bounds
   logic signed [BOUND_W-1:0] grp_lo [4] = '{64'sd0, BOUND_MIN, -64'sd50, 64'sd1};
   logic signed [BOUND_W-1:0] grp_hi [4] = '{64'sd0, BOUND_MAX, 64'sd50, -64'sd1};

   function automatic status_type classify_text();
      logic signed [BOUND_W-1:0] val;
      if (txt_bad || txt_count == 0) return STATUS_FORMAT;
      if (txt_lead && (txt_neg || txt_count > 1)) return STATUS_FORMAT;
      if (txt_big) return STATUS_RANGE;
      if (txt_neg ? (txt_mag > SIGN_BIT) : (txt_mag >= SIGN_BIT)) return STATUS_RANGE;
      val = txt_neg ? -txt_mag : txt_mag;
      if (val < bound_lo || val > bound_hi) return STATUS_RANGE;
      return STATUS_VALID;
   endfunction

   task automatic clear_text();
      txt_neg   = 1'b0;
      txt_count = '0;
      txt_mag   = '0;
      txt_big   = 1'b0;
      txt_lead  = 1'b0;
      txt_bad   = 1'b0;
      txt_begun = 1'b0;
   endtask

   task automatic absorb_char(input logic [7:0] ch, input logic lst, input int typed);
      logic [MAG_W-1:0] d;
      status_type       st;
      if (ch == CHAR_MINUS) begin
         if (txt_begun) txt_bad = 1'b1;
         else txt_neg = 1'b1;
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         d = {56'd0, ch - CHAR_ZERO};
         if (txt_count == 0 && d == 0) txt_lead = 1'b1;
         if (txt_count < COUNT_MAX) txt_count = txt_count + 1'b1;
         if (!txt_big) begin
            if (txt_mag > (MAG_ALL_ONES - d) / 10) begin
               txt_big = 1'b1;
               txt_mag = MAG_ALL_ONES;
            end else begin
               txt_mag = txt_mag * 10 + d;
            end
         end
      end else begin
         txt_bad = 1'b1;
      end
      txt_begun = 1'b1;
      if (lst) begin
         st = classify_text();
         status_due.push_back(typed < 0 ? st : status_type'(typed));
         clear_text();
      end
   endtask

   task automatic push_char(input logic [7:0] ch, input logic lst, input int typed);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      absorb_char(ch, lst, typed);
   endtask

   task automatic send_text(input int typed);
      for (int i = 0; i < text_buf.size(); i++)
         push_char(text_buf[i], i == text_buf.size() - 1, typed);
      text_buf.delete();
   endtask

   task automatic load_string(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   task automatic add_digits(input int n, input bit lead_ok);
      for (int i = 0; i < n; i++) begin
         if (i == 0 && !lead_ok) text_buf.push_back(CHAR_ZERO + 8'($urandom_range(1, 9)));
         else text_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
   endtask

   task automatic drain_results(input int extra);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (status_due.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic set_bounds(input logic signed [BOUND_W-1:0] lo,
                             input logic signed [BOUND_W-1:0] hi);
      csr_wr_en <= 1'b1;
      csr_index <= REG_LOW_BOUND;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= REG_HIGH_BOUND;
      csr_wdata <= hi;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      bound_lo = lo;
      bound_hi = hi;
   endtask

   // result side: random backpressure, compare against the oldest expectation
   initial begin : rsp_sink
      status_type due;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (status_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("rsp: unexpected transaction, tdata 0x%02h", rsp_tdata);
            end else begin
               due = status_due.pop_front();
               if (rsp_tdata !== {6'd0, due}) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("rsp: status expected %0d, got tdata 0x%02h", due, rsp_tdata);
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("decimal_integer_range_validator_core regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int                        group;
      int                        kind;
      int                        phase_chars;
      int                        len;
      int                        pos;
      bit                        paused;
      logic signed [BOUND_W-1:0] a;
      logic signed [BOUND_W-1:0] b;
      logic signed [BOUND_W-1:0] v;

      clear_text();
      bound_lo = '0;
      bound_hi = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      group = 0;
      send_idle_pct = 38;
      recv_idle_pct = 50;
      for (int r = 0; r < DIR_ROWS; r++) begin
         if (dir_group[r] != group) begin
            group = dir_group[r];
            drain_results(SETTLE_CYCLES);
            set_bounds(grp_lo[group], grp_hi[group]);
         end
         load_string(dir_text[r]);
         send_text(dir_want[r]);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain_results(SETTLE_CYCLES);
         a = $urandom_range(0, 100000);
         b = $urandom_range(0, 100000);
         case (phase)
            0: set_bounds(BOUND_MIN, BOUND_MAX);
            1: set_bounds(-a, b);
            2: set_bounds(a + 1, -a);
            3: set_bounds(a - 50000, a - 50000);
            4: begin
               a = {$urandom, $urandom};
               b = {$urandom, $urandom};
               if (a > b) set_bounds(b, a);
               else set_bounds(a, b);
            end
            default: set_bounds(BOUND_MIN, -64'sd1);
         endcase
         case (phase / 2)
            0: begin send_idle_pct = 38; recv_idle_pct = 50; end
            1: begin send_idle_pct = 50; recv_idle_pct = 38; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase

         phase_chars = 0;
         paused = 1'b0;
         while (phase_chars < PHASE_CHARS) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
               // value right around one of the bounds
               v = ($urandom_range(0, 1) ? bound_lo : bound_hi)
                   + $signed(64'($urandom_range(0, 6))) - 64'sd3;
               load_string($sformatf("%0d", v));
            end else if (kind < 65) begin
               if ($urandom_range(0, 9) < 3) text_buf.push_back(CHAR_MINUS);
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 6);
               add_digits(len, 1'b0);
            end else if (kind < 75) begin
               if ($urandom_range(0, 1)) text_buf.push_back(CHAR_MINUS);
               text_buf.push_back(CHAR_ZERO);
               add_digits($urandom_range(0, 3), 1'b1);
            end else if (kind < 85) begin
               len = $urandom_range(0, 5);
               pos = $urandom_range(1, len + 1);
               for (int i = 0; i <= len; i++) begin
                  if (i == pos) text_buf.push_back(CHAR_MINUS);
                  if (i < len) add_digits(1, i != 0);
               end
               if (len == 0 && $urandom_range(0, 1)) text_buf.delete(0);
               if (text_buf.size() == 0) text_buf.push_back(CHAR_MINUS);
            end else begin
               len = $urandom_range(1, 5);
               for (int i = 0; i < len; i++) text_buf.push_back(8'($urandom_range(0, 255)));
            end
            phase_chars += text_buf.size();
            send_text(NO_TYPED);
            if (!paused && phase_chars >= PHASE_CHARS / 2) begin
               paused = 1'b1;
               drain_results(0);
            end
         end
      end

      drain_results(SETTLE_CYCLES);
      if (fail_count == 0)
         $display("decimal_integer_range_validator_core regression: pass");
      else
         $display("decimal_integer_range_validator_core regression: fail");
      $finish;
   end

endmodule
